/* rtl/core/modexp_pkg.sv */
// Package for the modular exponentiation block: shared command/status types.
// No dependencies.
package modexp_pkg;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // latch operands, start message reduction
    logic mul_start; // start one product pair (multiply and square)
    logic err_load;  // set error result
  } modexp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic red_done;
    logic mul_done;
    logic last_bit;
  } modexp_sts_t;

endpackage

/* rtl/core/modexp_dp.sv */
// Datapath: operand registers, bit-serial modular reducer and two shift-add multipliers.
// Depends on modexp_pkg.
module modexp_dp #(
  parameter int WORD_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  modexp_pkg::modexp_cmd_t cmd_i,
  output modexp_pkg::modexp_sts_t sts_o,
  input  logic [63:0]             modulus_i,
  input  logic [63:0]             message_i,
  input  logic [63:0]             exponent_i,
  output logic [63:0]             result_o
);
  import modexp_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);
  localparam int EW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] n_q, r_q, t_q, e_q, acc_r_q, acc_t_q, msg_q;
  logic [EW-1:0]        ebit_q;
  logic [CW-1:0]        cnt_q;
  logic                 red_q, mul_q;

  // (x + y) mod n for x, y < n
  function automatic logic [WORD_BITS-1:0] mod_add(input logic [WORD_BITS-1:0] x,
      input logic [WORD_BITS-1:0] y, input logic [WORD_BITS-1:0] n);
    logic [WORD_BITS-1:0] gap;
    gap = n - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  logic [WORD_BITS-1:0] dbl_r, dbl_t, nxt_r, nxt_t, bit_idx_a;
  logic                 ar, at;
  logic [EW-1:0]        pos;

  assign pos   = EW'(cnt_q - CW'(1));
  assign ar    = r_q[pos];
  assign at    = t_q[pos];
  assign dbl_r = mod_add(acc_r_q, acc_r_q, n_q);
  assign dbl_t = mod_add(acc_t_q, acc_t_q, n_q);
  assign nxt_r = ar ? mod_add(dbl_r, t_q, n_q) : dbl_r;
  assign nxt_t = at ? mod_add(dbl_t, t_q, n_q) : dbl_t;
  // reduction: shift message bits MSB-first into acc_t (acc*2+bit mod n)
  assign bit_idx_a = mod_add(acc_t_q, acc_t_q, n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= 1'b0;
      mul_q   <= 1'b0;
      cnt_q   <= '0;
      n_q     <= '0;
      r_q     <= '0;
      t_q     <= '0;
      e_q     <= '0;
      acc_r_q <= '0;
      acc_t_q <= '0;
      msg_q   <= '0;
      ebit_q  <= '0;
    end else if (cmd_i.load) begin
      n_q     <= modulus_i[WORD_BITS-1:0];
      msg_q   <= message_i[WORD_BITS-1:0];
      e_q     <= exponent_i[WORD_BITS-1:0];
      acc_t_q <= '0;
      r_q     <= (modulus_i[WORD_BITS-1:0] == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
      ebit_q  <= '0;
      cnt_q   <= CW'(WORD_BITS);
      red_q   <= 1'b1;
    end else if (cmd_i.err_load) begin
      r_q <= '0;
    end else if (red_q) begin
      // bit-serial msg mod n; extra bit vs n handled by subtract after adding the message bit
      begin
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS:0]   w;
        w = {1'b0, bit_idx_a} + {{WORD_BITS{1'b0}}, msg_q[pos]};
        v = (w >= {1'b0, n_q}) ? WORD_BITS'(w - {1'b0, n_q}) : w[WORD_BITS-1:0];
        acc_t_q <= v;
        if (cnt_q == CW'(1)) begin
          t_q   <= v;
          red_q <= 1'b0;
        end
      end
      cnt_q <= cnt_q - CW'(1);
    end else if (cmd_i.mul_start) begin
      acc_r_q <= '0;
      acc_t_q <= '0;
      cnt_q   <= CW'(WORD_BITS);
      mul_q   <= 1'b1;
    end else if (mul_q) begin
      acc_r_q <= nxt_r;
      acc_t_q <= nxt_t;
      cnt_q   <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        mul_q <= 1'b0;
        if (e_q[ebit_q]) r_q <= nxt_r;
        t_q    <= nxt_t;
        ebit_q <= ebit_q + EW'(1);
      end
    end
  end

  assign sts_o.red_done = red_q && (cnt_q == CW'(1));
  assign sts_o.mul_done = mul_q && (cnt_q == CW'(1));
  assign sts_o.last_bit = (ebit_q == EW'(WORD_BITS - 1));
  assign result_o       = 64'(r_q);
endmodule

/* rtl/core/modexp_ctrl.sv */
// Controller: sequences reduction and one product pair per exponent bit; an even modulus goes to an error state.
// Depends on modexp_pkg.
module modexp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    mod_odd_i,
  input  modexp_pkg::modexp_sts_t sts_i,
  output modexp_pkg::modexp_cmd_t cmd_o,
  output logic                    busy,
  output logic                    done_o,
  output logic                    err_o
);
  import modexp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RED, S_MSTART, S_MUL, S_ERR} state_e;
  state_e state_q;

  assign busy = (state_q != S_IDLE);
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && start && mod_odd_i;
    cmd_o.err_load  = (state_q == S_IDLE) && start && !mod_odd_i;
    cmd_o.mul_start = (state_q == S_MSTART);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
      err_o   <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            err_o   <= !mod_odd_i;
            state_q <= mod_odd_i ? S_RED : S_ERR;
          end
        end
        S_ERR: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RED:    if (sts_i.red_done) state_q <= S_MSTART;
        S_MSTART: state_q <= S_MUL;
        S_MUL: begin
          if (sts_i.mul_done) begin
            if (sts_i.last_bit) begin
              done_o  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_MSTART;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == S_IDLE) else $error("done outside idle");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.mul_start)) else $error("load and mul together");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept without busy");
endmodule

/* rtl/core/modular_exponentiation_64_top.sv */
// Top level of the modular exponentiation block: config register, controller, datapath.
// Depends on modexp_pkg, modexp_ctrl, modexp_dp.
// Sequence: bit-serial reduction of the message, then one product pair per exponent bit, then
// the result; an even modulus skips both and answers zero with modulus_error_o set.
// A new item is taken only once busy has dropped; result strobe one cycle.
// Asynchronous active-low reset; modulus resets to 3.
module modular_exponentiation_64_top #(
  parameter int WORD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] message_i,
  input  logic [63:0] exponent_i,
  output logic        done_o,
  output logic [63:0] result_o,
  output logic        modulus_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);
  import modexp_pkg::*;

  logic [63:0]  modulus_q, res_w;
  modexp_cmd_t  cmd;
  modexp_sts_t  sts;
  logic         err;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) modulus_q <= 64'd3;
    else if (cfg_valid_i) modulus_q <= cfg_data_i;
  end

  modexp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .mod_odd_i(modulus_q[0]), .sts_i(sts), .cmd_o(cmd),
    .busy, .done_o, .err_o(err)
  );

  modexp_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .modulus_i(modulus_q),
    .message_i, .exponent_i, .result_o(res_w)
  );

  assign result_o        = err ? 64'd0 : res_w;
  assign modulus_error_o = err;
endmodule
